>>> rtl/dmfc_pkg.sv
// ----------------------------------------------------------------------------
// dmfc_pkg
// Widths, constants and control types shared by the divisor check block.
// ----------------------------------------------------------------------------
package dmfc_pkg;

    localparam int FACTOR_W  = 63;
    localparam int MULT_W    = 62;
    localparam int EXP_W     = 28;
    localparam int BIT_IDX_W = 6;
    localparam int EXP_IDX_W = 5;

    localparam logic [EXP_W-1:0]     EXP_RESET = EXP_W'(521);
    localparam logic [BIT_IDX_W-1:0] BIT_TOP   = BIT_IDX_W'(FACTOR_W - 1);
    localparam logic [EXP_IDX_W-1:0] EXP_TOP   = EXP_IDX_W'(EXP_W - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_DBL,
        S_ADD,
        S_JOB_END,
        S_SQ_SETUP,
        S_EXP_DBL,
        S_EXP_NEXT,
        S_SUB1,
        S_MUL_SETUP,
        S_FIN,
        S_ZERO
    } t_state;

    typedef enum logic [1:0] {
        JOB_REDK,
        JOB_SQR,
        JOB_MULT
    } t_job;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DBL_R,
        CMD_ADD_R,
        CMD_SAVE_M,
        CMD_SETUP_SQ,
        CMD_SAVE_ACC,
        CMD_DBL_ACC,
        CMD_SUB1,
        CMD_SETUP_MUL,
        CMD_FIN,
        CMD_ZERO
    } t_cmd;

    typedef struct packed {
        t_cmd                 cmd;
        logic [BIT_IDX_W-1:0] bit_idx;
        logic                 in_ready;
    } t_dp_ctrl;

    typedef struct packed {
        logic in_valid;
        logic b_bit;
        logic p_zero;
        logic out_busy;
    } t_dp_stat;

endpackage

>>> rtl/dmfc_if.sv
// ----------------------------------------------------------------------------
// dmfc_if
// Valid/ready channels of the divisor check block: input, result, config.
// ----------------------------------------------------------------------------
interface dmfc_in_if import dmfc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FACTOR_W-1:0] factor;
    logic [MULT_W-1:0]   multiplier;

    modport source (output valid, output factor, output multiplier, input ready);
    modport sink   (input valid, input factor, input multiplier, output ready);
endinterface

interface dmfc_out_if import dmfc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                divides;
    logic [FACTOR_W-1:0] remainder;

    modport source (output valid, output divides, output remainder, input ready);
    modport sink   (input valid, input divides, input remainder, output ready);
endinterface

interface dmfc_cfg_if import dmfc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [EXP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/dmfc_modadd.sv
// ----------------------------------------------------------------------------
// dmfc_modadd
// Shared modular adder: (x + y) mod p for x, y below p.
// ----------------------------------------------------------------------------
module dmfc_modadd import dmfc_pkg::*; (
    input  logic [FACTOR_W-1:0] i_x,
    input  logic [FACTOR_W-1:0] i_y,
    input  logic [FACTOR_W-1:0] i_p,
    output logic [FACTOR_W-1:0] o_sum
);

    logic [FACTOR_W:0] sum;
    logic [FACTOR_W:0] diff;

    assign sum   = {1'b0, i_x} + {1'b0, i_y};
    assign diff  = sum - {1'b0, i_p};
    assign o_sum = (sum >= {1'b0, i_p}) ? diff[FACTOR_W-1:0] : sum[FACTOR_W-1:0];

endmodule

>>> rtl/dmfc_ctrl.sv
// ----------------------------------------------------------------------------
// dmfc_ctrl
// Sequencer: double-and-add bit loop, exponent loop and result hand-off.
// ----------------------------------------------------------------------------
module dmfc_ctrl import dmfc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [EXP_W-1:0] i_exp,
    input  t_dp_stat         i_stat,
    output t_dp_ctrl         o_ctrl
);

    t_state               r_state, n_state;
    t_job                 r_job,   n_job;
    logic [BIT_IDX_W-1:0] r_idx,   n_idx;
    logic [EXP_IDX_W-1:0] r_ej,    n_ej;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= JOB_REDK;
            r_idx   <= '0;
            r_ej    <= '0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            r_idx   <= n_idx;
            r_ej    <= n_ej;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_idx   = r_idx;
        n_ej    = r_ej;
        case (r_state)
            S_IDLE: begin
                if (i_stat.in_valid) n_state = S_START;
            end
            S_START: begin
                if (i_stat.p_zero) begin
                    n_state = S_ZERO;
                end else begin
                    n_job   = JOB_REDK;
                    n_idx   = BIT_TOP;
                    n_state = S_DBL;
                end
            end
            S_DBL: begin
                if (i_stat.b_bit) begin
                    n_state = S_ADD;
                end else if (r_idx == '0) begin
                    n_state = S_JOB_END;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            S_ADD: begin
                if (r_idx == '0) begin
                    n_state = S_JOB_END;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = S_DBL;
                end
            end
            S_JOB_END: begin
                case (r_job)
                    JOB_REDK: begin
                        n_ej    = EXP_TOP;
                        n_state = S_SQ_SETUP;
                    end
                    JOB_SQR: begin
                        n_state = i_exp[r_ej] ? S_EXP_DBL : S_EXP_NEXT;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_SQ_SETUP: begin
                n_job   = JOB_SQR;
                n_idx   = BIT_TOP;
                n_state = S_DBL;
            end
            S_EXP_DBL: begin
                n_state = S_EXP_NEXT;
            end
            S_EXP_NEXT: begin
                if (r_ej == '0) begin
                    n_state = S_SUB1;
                end else begin
                    n_ej    = r_ej - 1'b1;
                    n_state = S_SQ_SETUP;
                end
            end
            S_SUB1: begin
                n_state = S_MUL_SETUP;
            end
            S_MUL_SETUP: begin
                n_job   = JOB_MULT;
                n_idx   = BIT_TOP;
                n_state = S_DBL;
            end
            S_FIN, S_ZERO: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl          = '0;
        o_ctrl.cmd      = CMD_NONE;
        o_ctrl.bit_idx  = r_idx;
        o_ctrl.in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                if (i_stat.in_valid) o_ctrl.cmd = CMD_LOAD;
            end
            S_DBL:       o_ctrl.cmd = CMD_DBL_R;
            S_ADD:       o_ctrl.cmd = CMD_ADD_R;
            S_JOB_END: begin
                case (r_job)
                    JOB_REDK: o_ctrl.cmd = CMD_SAVE_M;
                    JOB_SQR:  o_ctrl.cmd = CMD_SAVE_ACC;
                    default:  o_ctrl.cmd = CMD_NONE;
                endcase
            end
            S_SQ_SETUP:  o_ctrl.cmd = CMD_SETUP_SQ;
            S_EXP_DBL:   o_ctrl.cmd = CMD_DBL_ACC;
            S_SUB1:      o_ctrl.cmd = CMD_SUB1;
            S_MUL_SETUP: o_ctrl.cmd = CMD_SETUP_MUL;
            S_FIN: begin
                if (!i_stat.out_busy) o_ctrl.cmd = CMD_FIN;
            end
            S_ZERO: begin
                if (!i_stat.out_busy) o_ctrl.cmd = CMD_ZERO;
            end
            default: o_ctrl.cmd = CMD_NONE;
        endcase
    end

endmodule

>>> rtl/double_mersenne_factor_check.sv
// ----------------------------------------------------------------------------
// double_mersenne_factor_check
// Divisor check of 2*k*(2^n-1)+1 by a candidate p on one shared modular adder.
//
// Channels: i_in takes a word (factor p, multiplier k), o_out returns one
// word (divides, remainder) per input word, both valid/ready. i_cfg writes
// the exponent n; it is always ready and must be used only while idle.
// Each word runs on one modular adder: 2k mod p, then 28 squarings of
// 2^n mod p by double-and-add (a doubling per bit, plus an add for a set bit)
// with a doubling per set exponent bit, then subtract one, one more
// double-and-add product and a final add of one. The run time of a word is
// set by the popcount of 2k and of the squared values; a zero factor gives
// remainder zero, divides clear. Input is taken only while the sequencer is idle.
// The result sits in an output register; a stalled receiver holds it and the
// block may accept the next word, but it waits before its own result write
// until the old one is taken. Reset clears the sequencer and output valid
// and sets n to 521.
// ----------------------------------------------------------------------------
module double_mersenne_factor_check import dmfc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dmfc_in_if.sink    i_in,
    dmfc_out_if.source o_out,
    dmfc_cfg_if.sink   i_cfg
);

    logic [EXP_W-1:0]    r_exp;
    logic [FACTOR_W-1:0] r_p;
    logic [FACTOR_W-1:0] r_pm1;
    logic                r_one;
    logic                r_pz;
    logic [FACTOR_W-1:0] r_a;
    logic [FACTOR_W-1:0] r_b;
    logic [FACTOR_W-1:0] r_r;
    logic [FACTOR_W-1:0] r_m;
    logic [FACTOR_W-1:0] r_acc;
    logic                r_out_valid;
    logic                r_div;
    logic [FACTOR_W-1:0] r_rem;

    logic [FACTOR_W-1:0] op_x;
    logic [FACTOR_W-1:0] op_y;
    logic [FACTOR_W-1:0] sum;
    logic                load_one;
    t_dp_ctrl            ctrl;
    t_dp_stat            stat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= EXP_RESET;
        end else if (i_cfg.valid) begin
            r_exp <= i_cfg.data;
        end
    end

    assign stat.in_valid = i_in.valid;
    assign stat.b_bit    = r_b[ctrl.bit_idx];
    assign stat.p_zero   = r_pz;
    assign stat.out_busy = r_out_valid && !o_out.ready;

    dmfc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_exp   (r_exp),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    assign i_in.ready = ctrl.in_ready;

    always_comb begin
        op_x = r_r;
        op_y = r_r;
        case (ctrl.cmd)
            CMD_ADD_R: begin
                op_x = r_r;
                op_y = r_a;
            end
            CMD_DBL_ACC: begin
                op_x = r_acc;
                op_y = r_acc;
            end
            CMD_SUB1: begin
                op_x = r_acc;
                op_y = r_pm1;
            end
            CMD_FIN: begin
                op_x = r_r;
                op_y = {{(FACTOR_W-1){1'b0}}, r_one};
            end
            default: begin
                op_x = r_r;
                op_y = r_r;
            end
        endcase
    end

    dmfc_modadd u_modadd (
        .i_x   (op_x),
        .i_y   (op_y),
        .i_p   (r_p),
        .o_sum (sum)
    );

    // one mod p is zero only for p equal to one
    assign load_one = (i_in.factor != {{(FACTOR_W-1){1'b0}}, 1'b1});

    always_ff @(posedge i_clk) begin
        case (ctrl.cmd)
            CMD_LOAD: begin
                r_p   <= i_in.factor;
                r_pm1 <= i_in.factor - 1'b1;
                r_one <= load_one;
                r_pz  <= (i_in.factor == '0);
                r_a   <= {{(FACTOR_W-1){1'b0}}, load_one};
                r_b   <= {i_in.multiplier, 1'b0};
                r_r   <= '0;
                r_acc <= {{(FACTOR_W-1){1'b0}}, load_one};
            end
            CMD_DBL_R, CMD_ADD_R: begin
                r_r <= sum;
            end
            CMD_SAVE_M: begin
                r_m <= r_r;
            end
            CMD_SETUP_SQ: begin
                r_a <= r_acc;
                r_b <= r_acc;
                r_r <= '0;
            end
            CMD_SAVE_ACC: begin
                r_acc <= r_r;
            end
            CMD_DBL_ACC, CMD_SUB1: begin
                r_acc <= sum;
            end
            CMD_SETUP_MUL: begin
                r_a <= r_acc;
                r_b <= r_m;
                r_r <= '0;
            end
            CMD_FIN: begin
                r_rem <= sum;
                r_div <= (sum == '0);
            end
            CMD_ZERO: begin
                r_rem <= '0;
                r_div <= 1'b0;
            end
            default: begin
                r_r <= r_r;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.cmd == CMD_FIN || ctrl.cmd == CMD_ZERO) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.divides   = r_div;
    assign o_out.remainder = r_rem;

    // busy right after a word is taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while sequencer busy");

    // flag set only for a zero remainder
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.divides) |-> (o_out.remainder == '0))
        else $error("divides flag does not match remainder");

    // working values stay reduced mod p
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_in.ready && !r_pz) |-> (r_r < r_p && r_acc < r_p))
        else $error("working value not reduced");

    // a new result is never written over one still waiting
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> $stable(r_rem))
        else $error("pending result overwritten");

endmodule
